// ===== hdl/radix_digit_converter_defines.svh =====
// ----------------------------------------------------------------------------
// Radix digit converter assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define RDC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication that is checked in the cycle after the antecedent.
`define RDC_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter package
// Widths, defaults, sequencer states, divider status and the digit alphabet.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int MAX_DIGITS_DEFAULT = 64;

   localparam int VALUE_W = 64;
   localparam int RADIX_W = 8;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 6;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd62;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Maps a digit value onto 0-9, A-Z, a-z; codes beyond the alphabet give '0'.
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 6'd10) begin
         c = 8'h30 + {2'b00, d};
      end else if (d < 6'd36) begin
         c = 8'h37 + {2'b00, d};
      end else if (d < 6'd62) begin
         c = 8'h3D + {2'b00, d};
      end else begin
         c = 8'h30;
      end
      return c;
   endfunction

endpackage

// ===== hdl/rdc_divider.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter divider
// Restoring shift-subtract divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module rdc_divider #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_BITS-1:0]          dividend,
   input  logic [rdc_pkg::DIGIT_W-1:0]    divisor,
   output rdc_pkg::div_status_type        status,
   output logic [VALUE_BITS-1:0]          quotient,
   output logic [rdc_pkg::DIGIT_W-1:0]    remainder
);

   localparam int STEP_W = $clog2(VALUE_BITS + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [VALUE_BITS-1:0]         quo_ff, quo_in;
   logic [rdc_pkg::DIGIT_W-1:0]   rem_ff, rem_in;
   logic [rdc_pkg::DIGIT_W-1:0]   div_ff, div_in;

   logic [rdc_pkg::DIGIT_W:0]     trial;
   logic [rdc_pkg::DIGIT_W:0]     diff;
   logic                          fits;

   // The partial remainder stays below the divisor, so six bits plus the
   // incoming dividend bit are always enough.
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits  = (trial >= {1'b0, div_ff});
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VALUE_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[rdc_pkg::DIGIT_W-1:0] : trial[rdc_pkg::DIGIT_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status    = '{busy: busy_ff, done: done_ff};
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter
// Turns an unsigned number into ASCII digits in a radix from 2 to 62.
// ----------------------------------------------------------------------------
// One number is taken at a time; req_tready is high only while the block is
// idle. Each digit is worked out in the shared one-bit-per-clock divider, and
// each character is then sent through a read of the digit memory, then the
// output register. Zero gives the single character '0' and a radix outside
// 2..62 gives one word with tuser set and tdata zero. Numbers needing more
// than MAX_DIGITS digits lose the most significant ones. The output register
// lets the next number be taken while the last word waits.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // value [63:0], radix [71:64]
   input  logic [rdc_pkg::VALUE_W+rdc_pkg::RADIX_W-1:0]  req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // digit_char [7:0]
   output logic [rdc_pkg::CHAR_W-1:0]                    rsp_tdata,
   output logic                                          rsp_tlast,
   // bad_radix [0]
   output logic                                          rsp_tuser
);

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   rdc_pkg::state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]            quot_ff, quot_in;
   logic [rdc_pkg::DIGIT_W-1:0]      radix_ff, radix_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [IDX_W-1:0]                 rd_idx_ff, rd_idx_in;
   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [rdc_pkg::CHAR_W-1:0]       rsp_tdata_ff, rsp_tdata_in;
   logic                             rsp_tlast_ff, rsp_tlast_in;
   logic                             rsp_tuser_ff, rsp_tuser_in;

   logic [rdc_pkg::DIGIT_W-1:0]      digit_mem [MAX_DIGITS];
   logic [rdc_pkg::DIGIT_W-1:0]      rd_data_ff;
   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [rdc_pkg::DIGIT_W-1:0]      wr_data;

   logic [rdc_pkg::VALUE_W-1:0]      req_value;
   logic [rdc_pkg::RADIX_W-1:0]      req_radix;
   logic [VALUE_BITS-1:0]            value_masked;
   logic                             radix_bad;
   logic                             out_free;

   logic                             div_start;
   rdc_pkg::div_status_type          div_status;
   logic [VALUE_BITS-1:0]            div_quotient;
   logic [rdc_pkg::DIGIT_W-1:0]      div_remainder;

   assign req_value    = req_tdata[rdc_pkg::VALUE_W-1:0];
   assign req_radix    = req_tdata[rdc_pkg::VALUE_W +: rdc_pkg::RADIX_W];
   assign value_masked = req_value[VALUE_BITS-1:0];
   assign radix_bad    = (req_radix < rdc_pkg::RADIX_MIN) || (req_radix > rdc_pkg::RADIX_MAX);
   assign out_free     = !rsp_tvalid_ff || rsp_tready;

   rdc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (quot_ff),
      .divisor   (radix_ff),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in      = state_ff;
      quot_in       = quot_ff;
      radix_in      = radix_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = div_remainder;
      div_start     = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      unique case (state_ff)
         rdc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (radix_bad) begin
                  state_in = rdc_pkg::ST_BAD;
               end else begin
                  quot_in  = value_masked;
                  radix_in = req_radix[rdc_pkg::DIGIT_W-1:0];
                  count_in = '0;
                  if (value_masked == '0) begin
                     // Zero still yields one digit.
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_data   = '0;
                     count_in  = CNT_W'(1);
                     rd_idx_in = '0;
                     state_in  = rdc_pkg::ST_FETCH;
                  end else begin
                     state_in = rdc_pkg::ST_DIV_START;
                  end
               end
            end
         end
         rdc_pkg::ST_BAD: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tlast_in  = 1'b1;
               rsp_tuser_in  = 1'b1;
               state_in      = rdc_pkg::ST_IDLE;
            end
         end
         rdc_pkg::ST_DIV_START: begin
            if (!div_status.busy) begin
               div_start = 1'b1;
               state_in  = rdc_pkg::ST_DIV_WAIT;
            end
         end
         rdc_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               wr_en     = 1'b1;
               quot_in   = div_quotient;
               count_in  = count_ff + CNT_W'(1);
               rd_idx_in = count_ff[IDX_W-1:0];
               if ((div_quotient == '0) || (count_ff == CNT_W'(MAX_DIGITS - 1))) begin
                  state_in = rdc_pkg::ST_FETCH;
               end else begin
                  state_in = rdc_pkg::ST_DIV_START;
               end
            end
         end
         rdc_pkg::ST_FETCH: begin
            // The digit memory is read at this edge into rd_data_ff, which ST_EMIT uses.
            state_in = rdc_pkg::ST_EMIT;
         end
         rdc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = rdc_pkg::digit_to_ascii(rd_data_ff);
               rsp_tlast_in  = (rd_idx_ff == '0);
               rsp_tuser_in  = 1'b0;
               if (rd_idx_ff == '0) begin
                  state_in = rdc_pkg::ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - IDX_W'(1);
                  state_in  = rdc_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = rdc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rdc_pkg::ST_IDLE;
         quot_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         quot_ff       <= quot_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      radix_ff     <= radix_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // Digit memory: least significant digit at the lowest address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= digit_mem[rd_idx_ff];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== hdl/rdc_checker.sv =====
// ----------------------------------------------------------------------------
// Radix digit converter port checker
// Checks what the converter shows on its ports over time.
// ----------------------------------------------------------------------------
`include "radix_digit_converter_defines.svh"

module rdc_checker (
   input logic                                          clock,
   input logic                                          reset,
   input logic                                          req_tvalid,
   input logic                                          req_tready,
   input logic [rdc_pkg::VALUE_W+rdc_pkg::RADIX_W-1:0]  req_tdata,
   input logic                                          rsp_tvalid,
   input logic                                          rsp_tready,
   input logic [rdc_pkg::CHAR_W-1:0]                    rsp_tdata,
   input logic                                          rsp_tlast,
   input logic                                          rsp_tuser
);

   logic [rdc_pkg::RADIX_W-1:0] req_radix;
   logic                        char_is_digit;
   logic                        rsp_flagged;
   logic                        rsp_plain;
   logic                        flag_word_ok;
   logic                        req_take;
   logic                        rsp_stall;
   logic [rdc_pkg::CHAR_W+1:0]  rsp_word;

   assign req_radix = req_tdata[rdc_pkg::VALUE_W +: rdc_pkg::RADIX_W];

   assign char_is_digit = ((rsp_tdata >= 8'h30) && (rsp_tdata <= 8'h39)) ||
                          ((rsp_tdata >= 8'h41) && (rsp_tdata <= 8'h5A)) ||
                          ((rsp_tdata >= 8'h61) && (rsp_tdata <= 8'h7A));

   assign rsp_flagged  = rsp_tvalid && rsp_tuser;
   assign rsp_plain    = rsp_tvalid && !rsp_tuser;
   assign flag_word_ok = rsp_tlast && (rsp_tdata == '0);
   assign req_take     = req_tvalid && req_tready && (req_radix >= rdc_pkg::RADIX_MIN);
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_word     = {rsp_tdata, rsp_tlast, rsp_tuser};

   // A flagged radix is reported as a single, final, empty word.
   `RDC_ASSERT_IMP(a_bad_word, rsp_flagged, flag_word_ok, "flagged word is not a lone zero word")

   // Every unflagged word is a character of the alphabet.
   `RDC_ASSERT_IMP(a_char_alphabet, rsp_plain, char_is_digit, "character outside the alphabet")

   // Only one number is in work at a time (checked for a radix of at least RADIX_MIN).
   `RDC_ASSERT_NXT(a_one_at_a_time, req_take, !req_tready, "new number taken while one in work")

   // A stalled word holds its payload.
   `RDC_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "stalled word changed")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);
